[sv/thermistor_table_linearizer_core_macros.svh]
// assertion helpers for the thermistor linearizer
`ifndef THERMISTOR_TABLE_LINEARIZER_CORE_MACROS_SVH
`define THERMISTOR_TABLE_LINEARIZER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ttl assertion failed");

// next-cycle implication, checked outside reset
`define TTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ttl assertion failed");

// behavior right after a reset cycle
`define TTL_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("ttl reset assertion failed");

`endif

[sv/ttl_pkg.sv]
`default_nettype none

package ttl_pkg;

    localparam int R_W     = 20;
    localparam int ROM_W   = 18;
    localparam int IDX_W   = 7;
    localparam int DIFF_W  = 13;
    localparam int REM_W   = DIFF_W + 1;
    localparam int ROM_LEN = 111;
    localparam int OUT_W   = 16;

    localparam logic [R_W-1:0] COLD_R = R_W'(144790);
    localparam logic [R_W-1:0] HOT_R  = R_W'(1432);

    localparam int TEMP_LOW  = -30;
    localparam int TEMP_HIGH = 80;
    // entry n stands for n-30 degrees, interval base is n-31
    localparam int BASE_OFS  = 31;

    typedef enum logic [1:0] {
        ST_IN_RANGE = 2'd0,
        ST_COLD     = 2'd1,
        ST_HOT      = 2'd2
    } status_t;

    typedef struct packed {
        logic [R_W-1:0]   r;
        logic [IDX_W-1:0] pos;
        status_t          status;
    } search_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIFF_W-1:0] diff;
        logic [IDX_W-1:0]  idx;
        status_t           status;
    } div_t;

    // descending resistance, entry n at n-30 degrees
    localparam logic [ROM_W-1:0] RES_ROM [ROM_LEN] = '{
        18'd144790, 18'd136664, 18'd129054, 18'd121925, 18'd115243, 18'd109030,
        18'd103115, 18'd97565, 18'd92354, 18'd87460, 18'd82923, 18'd78581,
        18'd74497, 18'd70655, 18'd67039, 18'd63591, 18'd60381, 18'd57356,
        18'd54503, 18'd51813, 18'd49204, 18'd46767, 18'd44467, 18'd42296,
        18'd40247, 18'd38279, 18'd36455, 18'd34731, 18'd33100, 18'd31557,
        18'd30029, 18'd28627, 18'd27299, 18'd26042, 18'd24852, 18'd23773,
        18'd22708, 18'd21698, 18'd20739, 18'd19829, 18'd18959, 18'd18128,
        18'd17338, 18'd16588, 18'd15876, 18'd15207, 18'd14569, 18'd13962,
        18'd13384, 18'd12834, 18'd12280, 18'd11777, 18'd11297, 18'd10840,
        18'd10404, 18'd10000, 18'd9600, 18'd9218, 18'd8853, 18'd8506,
        18'd8178, 18'd7866, 18'd7568, 18'd7283, 18'd7011, 18'd6734,
        18'd6484, 18'd6244, 18'd6015, 18'd5796, 18'd5575, 18'd5373,
        18'd5180, 18'd4995, 18'd4817, 18'd4636, 18'd4473, 18'd4316,
        18'd4166, 18'd4021, 18'd3874, 18'd3737, 18'd3606, 18'd3481,
        18'd3360, 18'd3237, 18'd3126, 18'd3019, 18'd2917, 18'd2819,
        18'd2720, 18'd2629, 18'd2542, 18'd2458, 18'd2378, 18'd2304,
        18'd2229, 18'd2158, 18'd2089, 18'd2022, 18'd1960, 18'd1898,
        18'd1839, 18'd1782, 18'd1727, 18'd1673, 18'd1622, 18'd1573,
        18'd1526, 18'd1480, 18'd1432
    };

    // entries past the end read as zero
    function automatic logic [ROM_W-1:0] rom_value(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] v;
        v = '0;
        if (idx < IDX_W'(ROM_LEN)) begin
            v = RES_ROM[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/ttl_search_cell.sv]
`default_nettype none

// one binary search step: decides one bit of the count of entries above r
module ttl_search_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ttl_pkg::search_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ttl_pkg::search_t      out_data
);

    localparam logic [ttl_pkg::IDX_W-1:0] STEP = ttl_pkg::IDX_W'(1) << BIT;

    logic                        valid_reg;
    ttl_pkg::search_t            data_reg;
    ttl_pkg::search_t            data_next;
    logic [ttl_pkg::IDX_W-1:0]   cand;
    logic [ttl_pkg::IDX_W-1:0]   probe;
    logic                        above;

    always_comb begin
        cand      = in_data.pos | STEP;
        probe     = cand - ttl_pkg::IDX_W'(1);
        above     = {{(ttl_pkg::R_W - ttl_pkg::ROM_W){1'b0}}, ttl_pkg::rom_value(probe)}
                    > in_data.r;
        data_next = in_data;
        if (above) begin
            data_next.pos = cand;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[sv/ttl_div_cell.sv]
`default_nettype none

// one restoring division step: one quotient bit per cell
module ttl_div_cell #(
    parameter int unsigned QW = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ttl_pkg::div_t    in_data,
    input  wire logic [QW-1:0]    in_quot,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ttl_pkg::div_t         out_data,
    output logic [QW-1:0]         out_quot
);

    logic                        valid_reg;
    ttl_pkg::div_t               data_reg;
    ttl_pkg::div_t               data_next;
    logic [QW-1:0]               quot_reg;
    logic [QW:0]                 quot_ext;
    logic [ttl_pkg::REM_W-1:0]   rem_sub;
    logic                        ge;

    always_comb begin
        ge        = in_data.rem >= {1'b0, in_data.diff};
        rem_sub   = ge ? (in_data.rem - {1'b0, in_data.diff}) : in_data.rem;
        quot_ext  = {in_quot, ge};
        data_next = in_data;
        // remainder is below the divisor now, so the shift cannot overflow
        data_next.rem = {rem_sub[ttl_pkg::REM_W-2:0], 1'b0};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_quot  = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
            quot_reg <= quot_ext[QW-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/thermistor_table_linearizer_core.sv]
// throughput: one request per cycle unless m_ready stalls the output, set by the chain of search and divider cells
// 7 search cells, one table read stage, FRACTION_BITS + 1 divider cells, one output register
// every stage stalls on its own, so bubbles fill while a result waits
// reset: synchronous active low, clears the valid bits only; no table clearing
`default_nettype none

`include "thermistor_table_linearizer_core_macros.svh"

module thermistor_table_linearizer_core #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [19:0] s_resistance_ohms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_temperature_q8,
    output logic [1:0]       m_range_status
);

    localparam int QW       = FRACTION_BITS + 1;   // quotient may reach 2^FRACTION_BITS
    localparam int NUM_DIV  = FRACTION_BITS + 1;
    localparam int NUM_SRCH = ttl_pkg::IDX_W;
    localparam int CALC_W   = (FRACTION_BITS + 9 > ttl_pkg::OUT_W) ?
                              FRACTION_BITS + 9 : ttl_pkg::OUT_W;

    localparam logic signed [CALC_W-1:0] COLD_T =
        $signed(CALC_W'(ttl_pkg::TEMP_LOW)) <<< FRACTION_BITS;
    localparam logic signed [CALC_W-1:0] HOT_T =
        $signed(CALC_W'(ttl_pkg::TEMP_HIGH)) <<< FRACTION_BITS;
    localparam logic [ttl_pkg::OUT_W-1:0] COLD_Q = COLD_T[ttl_pkg::OUT_W-1:0];
    localparam logic [ttl_pkg::OUT_W-1:0] HOT_Q  = HOT_T[ttl_pkg::OUT_W-1:0];

    // ---------------------------------------------------------------
    // entry: range classification, search starts at count zero
    // ---------------------------------------------------------------
    ttl_pkg::search_t srch_data  [NUM_SRCH+1];
    logic             srch_valid [NUM_SRCH+1];
    logic             srch_ready [NUM_SRCH+1];

    always_comb begin
        srch_data[0].r      = s_resistance_ohms;
        srch_data[0].pos    = '0;
        srch_data[0].status = ttl_pkg::ST_IN_RANGE;
        if (s_resistance_ohms >= ttl_pkg::COLD_R) begin
            srch_data[0].status = ttl_pkg::ST_COLD;
        end else if (s_resistance_ohms <= ttl_pkg::HOT_R) begin
            srch_data[0].status = ttl_pkg::ST_HOT;
        end
    end

    assign srch_valid[0] = s_valid;
    assign s_ready       = srch_ready[0];

    // ---------------------------------------------------------------
    // search chain: msb first, ends with n = number of entries above r
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_SRCH; k++) begin : g_srch
        ttl_search_cell #(
            .BIT (NUM_SRCH - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (srch_valid[k]),
            .in_ready  (srch_ready[k]),
            .in_data   (srch_data[k]),
            .out_valid (srch_valid[k+1]),
            .out_ready (srch_ready[k+1]),
            .out_data  (srch_data[k+1])
        );
    end

    // ---------------------------------------------------------------
    // table read stage: interval ends, numerator and divisor
    // ---------------------------------------------------------------
    ttl_pkg::div_t div_data  [NUM_DIV+1];
    logic [QW-1:0] div_quot  [NUM_DIV+1];
    logic          div_valid [NUM_DIV+1];
    logic          div_ready [NUM_DIV+1];

    logic                          prep_valid_reg;
    ttl_pkg::div_t                 prep_data_reg;
    ttl_pkg::div_t                 prep_data_next;
    logic [ttl_pkg::ROM_W-1:0]     hi_r;
    logic [ttl_pkg::ROM_W-1:0]     lo_r;
    logic [ttl_pkg::R_W-1:0]       num_full;
    logic [ttl_pkg::ROM_W-1:0]     diff_full;

    always_comb begin
        hi_r      = ttl_pkg::rom_value(srch_data[NUM_SRCH].pos - ttl_pkg::IDX_W'(1));
        lo_r      = ttl_pkg::rom_value(srch_data[NUM_SRCH].pos);
        // inside the table r lies in [lo, hi), so both fit the divisor width
        num_full  = {{(ttl_pkg::R_W - ttl_pkg::ROM_W){1'b0}}, hi_r} - srch_data[NUM_SRCH].r;
        diff_full = hi_r - lo_r;
        prep_data_next.rem    = {1'b0, num_full[ttl_pkg::DIFF_W-1:0]};
        prep_data_next.diff   = diff_full[ttl_pkg::DIFF_W-1:0];
        prep_data_next.idx    = srch_data[NUM_SRCH].pos;
        prep_data_next.status = srch_data[NUM_SRCH].status;
    end

    assign srch_ready[NUM_SRCH] = !prep_valid_reg || div_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (srch_ready[NUM_SRCH]) begin
            prep_valid_reg <= srch_valid[NUM_SRCH];
        end
    end

    always_ff @(posedge aclk) begin
        if (srch_ready[NUM_SRCH] && srch_valid[NUM_SRCH]) begin
            prep_data_reg <= prep_data_next;
        end
    end

    assign div_valid[0] = prep_valid_reg;
    assign div_data[0]  = prep_data_reg;
    assign div_quot[0]  = '0;

    // ---------------------------------------------------------------
    // divider chain: floor(num * 2^FRACTION_BITS / diff), msb first
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
        ttl_div_cell #(
            .QW (QW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .in_quot   (div_quot[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1]),
            .out_quot  (div_quot[k+1])
        );
    end

    // ---------------------------------------------------------------
    // output register: base degree plus fraction, or clamped end
    // ---------------------------------------------------------------
    logic                         out_valid_reg;
    logic [ttl_pkg::OUT_W-1:0]    temp_reg;
    logic [ttl_pkg::OUT_W-1:0]    temp_next;
    ttl_pkg::status_t             status_reg;
    logic signed [CALC_W-1:0]     idx_s;
    logic signed [CALC_W-1:0]     base_s;
    logic signed [CALC_W-1:0]     frac_s;
    logic signed [CALC_W-1:0]     sum_s;

    always_comb begin
        idx_s  = $signed({{(CALC_W - ttl_pkg::IDX_W){1'b0}}, div_data[NUM_DIV].idx});
        base_s = (idx_s - $signed(CALC_W'(ttl_pkg::BASE_OFS))) <<< FRACTION_BITS;
        frac_s = $signed({{(CALC_W - QW){1'b0}}, div_quot[NUM_DIV]});
        sum_s  = base_s + frac_s;
        case (div_data[NUM_DIV].status)
            ttl_pkg::ST_COLD: temp_next = COLD_Q;
            ttl_pkg::ST_HOT:  temp_next = HOT_Q;
            default:          temp_next = sum_s[ttl_pkg::OUT_W-1:0];
        endcase
    end

    assign div_ready[NUM_DIV] = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (div_ready[NUM_DIV]) begin
            out_valid_reg <= div_valid[NUM_DIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready[NUM_DIV] && div_valid[NUM_DIV]) begin
            temp_reg   <= temp_next;
            status_reg <= div_data[NUM_DIV].status;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_temperature_q8 = $signed(temp_reg);
    assign m_range_status   = status_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // input back-pressure only when every stage is full and the result waits
    `TTL_ASSERT_NOW(a_stall_needs_full, !s_ready, m_valid && !m_ready)
    `TTL_ASSERT_NOW(a_cold_value, m_valid && (m_range_status == ttl_pkg::ST_COLD),
        m_temperature_q8 == $signed(COLD_Q))
    `TTL_ASSERT_NOW(a_hot_value, m_valid && (m_range_status == ttl_pkg::ST_HOT),
        m_temperature_q8 == $signed(HOT_Q))
    `TTL_ASSERT_RESET(a_reset_empty, !m_valid)

endmodule

`default_nettype wire
